@@ rtl/reb_pkg.sv @@
// shared types, register codes and the quadrature weight table for the
// rotary encoder / button decoder; no dependencies
package reb_pkg;

  localparam int CFG_W       = 12;
  localparam int CFG_IDX_W   = 2;
  localparam int THR_W       = 4;
  localparam int IN_DATA_W   = 8;
  localparam int OUT_DATA_W  = 16;
  localparam int TURN_OUT_W  = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEBOUNCE  = 2'd0,
    REG_MIN_SHORT = 2'd1,
    REG_LONG      = 2'd2,
    REG_THRESHOLD = 2'd3
  } cfg_reg_t;

  localparam logic [CFG_W-1:0] DEBOUNCE_RESET  = 12'd20;
  localparam logic [CFG_W-1:0] MIN_SHORT_RESET = 12'd35;
  localparam logic [CFG_W-1:0] LONG_RESET      = 12'd700;
  localparam logic [THR_W-1:0] THRESHOLD_RESET = 4'd4;

  typedef struct packed {
    logic [CFG_W-1:0] debounce_ticks;
    logic [CFG_W-1:0] min_short_ticks;
    logic [CFG_W-1:0] long_press_ticks;
    logic [THR_W-1:0] step_threshold;
  } cfg_t;

  // one sample as it travels from the input register into the update logic
  typedef struct packed {
    logic step;       // a sample is processed this cycle
    logic first;      // first sample since reset
    logic [1:0] ab;   // {enc_a, enc_b}
    logic raw;
    logic tick;
    logic take_turns;
    logic take_short;
    logic take_long;
  } sample_t;

  // quadrature weight of a transition from prev to cur: +1, -1, or 0
  function automatic logic signed [1:0] quad_weight(input logic [1:0] prev,
                                                    input logic [1:0] cur);
    logic signed [1:0] w;
    unique case ({prev, cur})
      4'h1, 4'h7, 4'h8, 4'hE: w = -2'sd1;
      4'h2, 4'h4, 4'hB, 4'hD: w = 2'sd1;
      default:                w = 2'sd0;
    endcase
    return w;
  endfunction

endpackage

@@ rtl/reb_encoder.sv @@
// quadrature decoder: quarter-step count, detent check and saturating turn count
// depends on reb_pkg
module reb_encoder #(
  parameter int TURN_BITS     = 8,
  parameter int QUARTER_LIMIT = 8
) (
  input  logic                               clk,
  input  logic                               rst,
  input  reb_pkg::sample_t                   smp,
  input  logic [reb_pkg::THR_W-1:0]          step_threshold,
  output logic [reb_pkg::TURN_OUT_W-1:0]     turn_count
);
  import reb_pkg::*;

  localparam int QW = $clog2(QUARTER_LIMIT + 2) + 1;
  localparam logic signed [TURN_BITS-1:0] TURN_MAX = {1'b0, {(TURN_BITS-1){1'b1}}};
  localparam logic signed [7:0] QLIM = 8'(QUARTER_LIMIT);

  logic [1:0] last_ab, last_ab_next;
  logic [1:0] detent_ab, detent_ab_next;
  logic signed [QW-1:0] quarter_count, quarter_count_next;
  logic signed [TURN_BITS-1:0] turn_total, turn_total_next, turn_upd;
  logic signed [7:0] sum;
  logic signed [7:0] clamped;
  logic signed [7:0] thr;
  logic signed [31:0] turn_ext;

  always_comb begin
    last_ab_next       = last_ab;
    detent_ab_next     = detent_ab;
    quarter_count_next = quarter_count;
    turn_upd           = turn_total;
    sum     = 8'(quarter_count) + 8'(quad_weight(last_ab, smp.ab));
    clamped = sum;
    if (sum > QLIM) begin
      clamped = QLIM;
    end else if (sum < -QLIM) begin
      clamped = -QLIM;
    end
    // a threshold of zero behaves as one
    thr = (step_threshold == '0) ? 8'sd1 : $signed({4'b0, step_threshold});
    if (smp.first) begin
      last_ab_next   = smp.ab;
      detent_ab_next = smp.ab;
    end else if (smp.ab != last_ab) begin
      last_ab_next       = smp.ab;
      quarter_count_next = QW'(clamped);
      if (smp.ab == detent_ab) begin
        if (clamped >= thr) begin
          if (turn_total < TURN_MAX) turn_upd = turn_total + 1'b1;
        end else if (clamped <= -thr) begin
          if (turn_total > -TURN_MAX) turn_upd = turn_total - 1'b1;
        end
        quarter_count_next = '0;
      end
    end
    turn_total_next = smp.take_turns ? '0 : turn_upd;
    turn_ext   = 32'(turn_upd);
    turn_count = turn_ext[TURN_OUT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_ab       <= '0;
      detent_ab     <= '0;
      quarter_count <= '0;
      turn_total    <= '0;
    end else if (smp.step) begin
      last_ab       <= last_ab_next;
      detent_ab     <= detent_ab_next;
      quarter_count <= quarter_count_next;
      turn_total    <= turn_total_next;
    end
  end

endmodule

@@ rtl/reb_button.sv @@
// button debounce with tick counters, short and long press events
// depends on reb_pkg
module reb_button #(
  parameter int TIME_BITS = 12
) (
  input  logic             clk,
  input  logic             rst,
  input  reb_pkg::sample_t smp,
  input  reb_pkg::cfg_t    cfg,
  output logic             short_press,
  output logic             long_press,
  output logic             button_down
);
  import reb_pkg::*;

  localparam int CMP_W = (TIME_BITS > CFG_W) ? TIME_BITS : CFG_W;

  logic raw_level, raw_level_next;
  logic stable_level, stable_level_next;
  logic [TIME_BITS-1:0] raw_age, raw_age_next;
  logic [TIME_BITS-1:0] press_age, press_age_next;
  logic long_reported, long_reported_next;
  logic short_pending, short_pending_next, short_upd;
  logic long_pending, long_pending_next, long_upd;

  always_comb begin
    raw_level_next     = raw_level;
    stable_level_next  = stable_level;
    raw_age_next       = raw_age;
    press_age_next     = press_age;
    long_reported_next = long_reported;
    short_upd          = short_pending;
    long_upd           = long_pending;
    if (smp.first) begin
      raw_level_next     = smp.raw;
      stable_level_next  = smp.raw;
      raw_age_next       = '0;
      press_age_next     = '0;
      long_reported_next = 1'b0;
    end else begin
      // tick counters saturate
      if (smp.tick) begin
        if (raw_age != '1) raw_age_next = raw_age + 1'b1;
        if (press_age != '1) press_age_next = press_age + 1'b1;
      end
      if (smp.raw != raw_level) begin
        raw_level_next = smp.raw;
        raw_age_next   = '0;
      end
      if (CMP_W'(raw_age_next) >= CMP_W'(cfg.debounce_ticks) &&
          stable_level != raw_level_next) begin
        stable_level_next = raw_level_next;
        if (raw_level_next) begin
          press_age_next     = '0;
          long_reported_next = 1'b0;
        end else if (!long_reported &&
                     CMP_W'(press_age_next) >= CMP_W'(cfg.min_short_ticks)) begin
          short_upd = 1'b1;
        end
      end
      if (stable_level_next && !long_reported_next &&
          CMP_W'(press_age_next) >= CMP_W'(cfg.long_press_ticks)) begin
        long_upd           = 1'b1;
        long_reported_next = 1'b1;
      end
    end
    short_press        = short_upd;
    long_press         = long_upd;
    button_down        = stable_level_next;
    short_pending_next = short_upd && !smp.take_short;
    long_pending_next  = long_upd && !smp.take_long;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      raw_level     <= 1'b0;
      stable_level  <= 1'b0;
      raw_age       <= '0;
      press_age     <= '0;
      long_reported <= 1'b0;
      short_pending <= 1'b0;
      long_pending  <= 1'b0;
    end else if (smp.step) begin
      raw_level     <= raw_level_next;
      stable_level  <= stable_level_next;
      raw_age       <= raw_age_next;
      press_age     <= press_age_next;
      long_reported <= long_reported_next;
      short_pending <= short_pending_next;
      long_pending  <= long_pending_next;
    end
  end

endmodule

@@ rtl/rotary_encoder_button_decoder.sv @@
// rotary encoder and push button decoder, top level with stream ports
// depends on reb_pkg, reb_encoder, reb_button
//
// Each transfer on the input stream is one sample of the encoder lines, the raw
// button level and a millisecond tick; each sample gives exactly one result
// transfer with the turn count, the pending short and long press flags and the
// debounced button level. A sample waits in the input register until the update
// logic can take it, which then writes its result into the output register, from
// which it is offered; one sample is taken every cycle while the output side
// keeps up, and the input register holds the next sample while a result waits.
// The first sample after reset only sets the detent position and button state.
// Configuration writes take effect at once and belong in idle periods.
module rotary_encoder_button_decoder #(
  parameter int TIME_BITS     = 12,
  parameter int TURN_BITS     = 8,
  parameter int QUARTER_LIMIT = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // enc_a, enc_b, button_raw_pressed, ms_tick, take_turns, take_short,
  // take_long, zero fill
  input  logic [reb_pkg::IN_DATA_W-1:0]     s_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // turn_count[7:0], short_press, long_press, button_down, zero fill
  output logic [reb_pkg::OUT_DATA_W-1:0]    m_tdata,
  input  logic                              cfg_we,
  input  logic [reb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [reb_pkg::CFG_W-1:0]         cfg_data
);
  import reb_pkg::*;

  cfg_t cfg;
  logic in_valid;
  logic [IN_DATA_W-1:0] in_data;
  logic started;
  logic fire;
  sample_t smp;
  logic [TURN_OUT_W-1:0] turn_count;
  logic short_press, long_press, button_down;
  logic [OUT_DATA_W-1:0] out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ticks   <= DEBOUNCE_RESET;
      cfg.min_short_ticks  <= MIN_SHORT_RESET;
      cfg.long_press_ticks <= LONG_RESET;
      cfg.step_threshold   <= THRESHOLD_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_DEBOUNCE:  cfg.debounce_ticks   <= cfg_data;
        REG_MIN_SHORT: cfg.min_short_ticks  <= cfg_data;
        REG_LONG:      cfg.long_press_ticks <= cfg_data;
        REG_THRESHOLD: cfg.step_threshold   <= cfg_data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // process the held sample when the result register is free or draining
  assign fire     = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      started  <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (s_tready) in_valid <= s_tvalid;
      if (fire) started <= 1'b1;
      if (fire) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) in_data <= s_tdata;
    if (fire) m_tdata <= out_data;
  end

  always_comb begin
    smp.step       = fire;
    smp.first      = !started;
    smp.ab         = {in_data[0], in_data[1]};
    smp.raw        = in_data[2];
    smp.tick       = in_data[3];
    smp.take_turns = in_data[4];
    smp.take_short = in_data[5];
    smp.take_long  = in_data[6];
  end

  reb_encoder #(
    .TURN_BITS     (TURN_BITS),
    .QUARTER_LIMIT (QUARTER_LIMIT)
  ) u_encoder (
    .clk            (clk),
    .rst            (rst),
    .smp            (smp),
    .step_threshold (cfg.step_threshold),
    .turn_count     (turn_count)
  );

  reb_button #(
    .TIME_BITS (TIME_BITS)
  ) u_button (
    .clk         (clk),
    .rst         (rst),
    .smp         (smp),
    .cfg         (cfg),
    .short_press (short_press),
    .long_press  (long_press),
    .button_down (button_down)
  );

  assign out_data = {5'b0, button_down, long_press, short_press, turn_count};

  // turn count saturates symmetrically, never reaching the most negative code
  a_turn_sym: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[TURN_OUT_W-1:0] != 8'h80)
    else $error("turn count reached the most negative code");

  // a held sample that could not be processed stays held
  a_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !fire |=> in_valid)
    else $error("held sample was dropped");

  // once a sample has been processed the block counts as started
  a_started: assert property (@(posedge clk) disable iff (rst)
    fire |=> started)
    else $error("started flag not set after first sample");

  // a new result is only produced when the output side can take it
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("pending result overwritten");

endmodule
